@@ rtl/aes128_block_encrypt_core_defines.svh @@
// Assertion helpers shared by the core.
`ifndef AES128_BLOCK_ENCRYPT_CORE_DEFINES_SVH
`define AES128_BLOCK_ENCRYPT_CORE_DEFINES_SVH

// Check a consequence in the same cycle as its antecedent.
`define AESB_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Check a consequence in the cycle after its antecedent.
`define AESB_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/aesb_pkg.sv @@
package aesb_pkg;

    localparam int ROUNDS  = 10;
    localparam int RK_ROWS = ROUNDS + 1;
    localparam int RK_AW   = $clog2(RK_ROWS);

    localparam logic [RK_AW-1:0] LAST_ROW  = RK_AW'(ROUNDS);
    localparam logic [RK_AW-1:0] FIRST_ROW = '0;

    localparam logic [7:0] GF_POLY   = 8'h1b;
    localparam logic [7:0] RCON_INIT = 8'h01;

    // Configuration register indexes
    localparam logic CFG_KEY_HIGH = 1'b0;
    localparam logic CFG_KEY_LOW  = 1'b1;

    // Round-key memory write port; one row holds the four words of a round key
    typedef struct packed {
        logic             we;
        logic [RK_AW-1:0] addr;
        logic [127:0]     data;
    } t_rk_wr;

    localparam logic [7:0] SBOX [256] = '{
        8'h63, 8'h7c, 8'h77, 8'h7b, 8'hf2, 8'h6b, 8'h6f, 8'hc5,
        8'h30, 8'h01, 8'h67, 8'h2b, 8'hfe, 8'hd7, 8'hab, 8'h76,
        8'hca, 8'h82, 8'hc9, 8'h7d, 8'hfa, 8'h59, 8'h47, 8'hf0,
        8'had, 8'hd4, 8'ha2, 8'haf, 8'h9c, 8'ha4, 8'h72, 8'hc0,
        8'hb7, 8'hfd, 8'h93, 8'h26, 8'h36, 8'h3f, 8'hf7, 8'hcc,
        8'h34, 8'ha5, 8'he5, 8'hf1, 8'h71, 8'hd8, 8'h31, 8'h15,
        8'h04, 8'hc7, 8'h23, 8'hc3, 8'h18, 8'h96, 8'h05, 8'h9a,
        8'h07, 8'h12, 8'h80, 8'he2, 8'heb, 8'h27, 8'hb2, 8'h75,
        8'h09, 8'h83, 8'h2c, 8'h1a, 8'h1b, 8'h6e, 8'h5a, 8'ha0,
        8'h52, 8'h3b, 8'hd6, 8'hb3, 8'h29, 8'he3, 8'h2f, 8'h84,
        8'h53, 8'hd1, 8'h00, 8'hed, 8'h20, 8'hfc, 8'hb1, 8'h5b,
        8'h6a, 8'hcb, 8'hbe, 8'h39, 8'h4a, 8'h4c, 8'h58, 8'hcf,
        8'hd0, 8'hef, 8'haa, 8'hfb, 8'h43, 8'h4d, 8'h33, 8'h85,
        8'h45, 8'hf9, 8'h02, 8'h7f, 8'h50, 8'h3c, 8'h9f, 8'ha8,
        8'h51, 8'ha3, 8'h40, 8'h8f, 8'h92, 8'h9d, 8'h38, 8'hf5,
        8'hbc, 8'hb6, 8'hda, 8'h21, 8'h10, 8'hff, 8'hf3, 8'hd2,
        8'hcd, 8'h0c, 8'h13, 8'hec, 8'h5f, 8'h97, 8'h44, 8'h17,
        8'hc4, 8'ha7, 8'h7e, 8'h3d, 8'h64, 8'h5d, 8'h19, 8'h73,
        8'h60, 8'h81, 8'h4f, 8'hdc, 8'h22, 8'h2a, 8'h90, 8'h88,
        8'h46, 8'hee, 8'hb8, 8'h14, 8'hde, 8'h5e, 8'h0b, 8'hdb,
        8'he0, 8'h32, 8'h3a, 8'h0a, 8'h49, 8'h06, 8'h24, 8'h5c,
        8'hc2, 8'hd3, 8'hac, 8'h62, 8'h91, 8'h95, 8'he4, 8'h79,
        8'he7, 8'hc8, 8'h37, 8'h6d, 8'h8d, 8'hd5, 8'h4e, 8'ha9,
        8'h6c, 8'h56, 8'hf4, 8'hea, 8'h65, 8'h7a, 8'hae, 8'h08,
        8'hba, 8'h78, 8'h25, 8'h2e, 8'h1c, 8'ha6, 8'hb4, 8'hc6,
        8'he8, 8'hdd, 8'h74, 8'h1f, 8'h4b, 8'hbd, 8'h8b, 8'h8a,
        8'h70, 8'h3e, 8'hb5, 8'h66, 8'h48, 8'h03, 8'hf6, 8'h0e,
        8'h61, 8'h35, 8'h57, 8'hb9, 8'h86, 8'hc1, 8'h1d, 8'h9e,
        8'he1, 8'hf8, 8'h98, 8'h11, 8'h69, 8'hd9, 8'h8e, 8'h94,
        8'h9b, 8'h1e, 8'h87, 8'he9, 8'hce, 8'h55, 8'h28, 8'hdf,
        8'h8c, 8'ha1, 8'h89, 8'h0d, 8'hbf, 8'he6, 8'h42, 8'h68,
        8'h41, 8'h99, 8'h2d, 8'h0f, 8'hb0, 8'h54, 8'hbb, 8'h16
    };

    function automatic logic [7:0] f_sbox(input logic [7:0] x);
        return SBOX[x];
    endfunction

    // Multiply by x in GF(2^8)
    function automatic logic [7:0] f_xtime(input logic [7:0] x);
        return {x[6:0], 1'b0} ^ (x[7] ? GF_POLY : 8'h00);
    endfunction

endpackage

@@ rtl/aesb_rkmem.sv @@
module aesb_rkmem
    import aesb_pkg::*;
(
    input  logic             i_clk,
    input  t_rk_wr           i_wr,
    input  logic [RK_AW-1:0] i_raddr,
    output logic [127:0]     o_rdata
);

    logic [127:0] r_mem [RK_ROWS];
    logic [127:0] r_rdata;

    // Write one round-key row
    always_ff @(posedge i_clk) begin
        if (i_wr.we) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
    end

    // Registered read: the row appears in the cycle after its address
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/aesb_keygen.sv @@
module aesb_keygen
    import aesb_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_start,
    input  logic [127:0] i_key,
    output logic         o_busy,
    output t_rk_wr       o_wr
);

    logic             r_busy;
    logic [RK_AW-1:0] r_row;
    logic [127:0]     r_kw;
    logic [7:0]       r_rcon;
    logic [127:0]     n_kw;

    // Derive the next round key from the previous one
    always_comb begin
        logic [31:0] w0, w1, w2, w3, t, rot;
        w0  = r_kw[127:96];
        w1  = r_kw[95:64];
        w2  = r_kw[63:32];
        w3  = r_kw[31:0];
        rot = {w3[23:0], w3[31:24]};
        t   = {f_sbox(rot[31:24]) ^ r_rcon, f_sbox(rot[23:16]),
               f_sbox(rot[15:8]), f_sbox(rot[7:0])};
        n_kw[127:96] = w0 ^ t;
        n_kw[95:64]  = w1 ^ n_kw[127:96];
        n_kw[63:32]  = w2 ^ n_kw[95:64];
        n_kw[31:0]   = w3 ^ n_kw[63:32];
    end

    // Sequence through the rows, one round key per cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_row  <= FIRST_ROW;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_row  <= FIRST_ROW + RK_AW'(1);
        end else if (r_busy) begin
            if (r_row == LAST_ROW) begin
                r_busy <= 1'b0;
            end
            r_row <= r_row + RK_AW'(1);
        end
    end

    // Previous round key and round constant
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_kw   <= i_key;
            r_rcon <= RCON_INIT;
        end else if (r_busy) begin
            r_kw   <= n_kw;
            r_rcon <= f_xtime(r_rcon);
        end
    end

    assign o_busy  = r_busy;
    assign o_wr.we   = i_start | r_busy;
    assign o_wr.addr = i_start ? FIRST_ROW : r_row;
    assign o_wr.data = i_start ? i_key : n_kw;

endmodule

@@ rtl/aesb_cipher.sv @@
module aesb_cipher
    import aesb_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_load,
    input  logic [127:0]     i_plain,
    input  logic [127:0]     i_rk,
    output logic [RK_AW-1:0] o_raddr,
    output logic             o_busy,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output logic [127:0]     o_cipher
);

    localparam logic ST_IDLE  = 1'b0;
    localparam logic ST_ROUND = 1'b1;

    logic             r_state, n_state;
    logic [RK_AW-1:0] r_rnd, n_rnd;
    logic [127:0]     r_st;
    logic             r_out_valid;
    logic [127:0]     r_out;
    logic             out_free;
    logic             finish;
    logic [127:0]     round_out;

    // SubBytes, ShiftRows and, but for the final round, MixColumns
    function automatic logic [127:0] f_round(input logic [127:0] s, input logic last);
        logic [7:0]   b [16];
        logic [7:0]   t [16];
        logic [7:0]   a0, a1, a2, a3, all;
        logic [127:0] o;
        for (int i = 0; i < 16; i++) begin
            b[i] = s[127 - 8 * i -: 8];
        end
        for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
                t[4 * c + r] = f_sbox(b[4 * ((c + r) & 3) + r]);
            end
        end
        if (!last) begin
            for (int c = 0; c < 4; c++) begin
                a0  = t[4 * c];
                a1  = t[4 * c + 1];
                a2  = t[4 * c + 2];
                a3  = t[4 * c + 3];
                all = a0 ^ a1 ^ a2 ^ a3;
                t[4 * c]     = a0 ^ all ^ f_xtime(a0 ^ a1);
                t[4 * c + 1] = a1 ^ all ^ f_xtime(a1 ^ a2);
                t[4 * c + 2] = a2 ^ all ^ f_xtime(a2 ^ a3);
                t[4 * c + 3] = a3 ^ all ^ f_xtime(a3 ^ a0);
            end
        end
        for (int i = 0; i < 16; i++) begin
            o[127 - 8 * i -: 8] = t[i];
        end
        return o;
    endfunction

    assign out_free  = !r_out_valid || i_out_ready;
    assign finish    = (r_state == ST_ROUND) && (r_rnd == LAST_ROW) && out_free;
    assign round_out = f_round(r_st, r_rnd == LAST_ROW) ^ i_rk;

    // Round sequencing; hold the final round while the result register is full and not taken
    always_comb begin
        n_state = r_state;
        n_rnd   = r_rnd;
        case (r_state)
            ST_IDLE: begin
                if (i_load) begin
                    n_state = ST_ROUND;
                    n_rnd   = FIRST_ROW + RK_AW'(1);
                end
            end
            ST_ROUND: begin
                if (r_rnd != LAST_ROW) begin
                    n_rnd = r_rnd + RK_AW'(1);
                end else if (out_free) begin
                    n_state = ST_IDLE;
                    n_rnd   = FIRST_ROW;
                end
            end
            default: begin
                n_state = ST_IDLE;
                n_rnd   = FIRST_ROW;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_rnd   <= FIRST_ROW;
        end else begin
            r_state <= n_state;
            r_rnd   <= n_rnd;
        end
    end

    // Initial key addition on load, one round per cycle after, the final round held while the result register is full
    always_ff @(posedge i_clk) begin
        if (r_state == ST_IDLE) begin
            r_st <= i_plain ^ i_rk;
        end else if (r_rnd != LAST_ROW) begin
            r_st <= round_out;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (finish) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (finish) begin
            r_out <= round_out;
        end
    end

    // Fetch the key row for the next cycle's round
    assign o_raddr     = n_rnd;
    assign o_busy      = (r_state == ST_ROUND);
    assign o_out_valid = r_out_valid;
    assign o_cipher    = r_out;

endmodule

@@ rtl/aes128_block_encrypt_core.sv @@
// Channel   | Direction | Handshake                    | Payload
// s_axis    | in        | s_axis_tvalid/s_axis_tready  | plain_high, plain_low
// m_axis    | out       | m_axis_tvalid/m_axis_tready  | cipher_high, cipher_low
// i_cfg     | in        | i_cfg_we                     | 0 key_high, 1 key_low
//
// A block gets the initial key addition, then one round per cycle (the final
// round held while the result register is full) on a 16 S-box datapath fed one
// round-key row a cycle from the key memory. After a key write the 11-row key
// memory is refilled, one row a cycle, before the next block is taken.
// Reset clears the key registers and all control; the key memory is not
// cleared. A full result register holds the final round until it drains.
`include "aes128_block_encrypt_core_defines.svh"

module aes128_block_encrypt_core
    import aesb_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [127:0] s_axis_tdata,   // plain_high [63:0], plain_low [127:64]
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [127:0] m_axis_tdata,   // cipher_high [63:0], cipher_low [127:64]
    input  logic         i_cfg_we,
    input  logic         i_cfg_addr,
    input  logic [63:0]  i_cfg_wdata
);

    logic [63:0]      r_key_high;
    logic [63:0]      r_key_low;
    logic             r_pending;
    logic             kg_busy;
    logic             kg_start;
    t_rk_wr           kg_wr;
    logic             ci_busy;
    logic             accept;
    logic [RK_AW-1:0] raddr;
    logic [127:0]     rk;
    logic [127:0]     cipher;

    // Key registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_high <= '0;
            r_key_low  <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                CFG_KEY_HIGH: r_key_high <= i_cfg_wdata;
                CFG_KEY_LOW:  r_key_low  <= i_cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    // Mark the key memory stale on a key write; drop the mark when refill starts
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending <= 1'b0;
        end else if (i_cfg_we) begin
            r_pending <= 1'b1;
        end else if (kg_start) begin
            r_pending <= 1'b0;
        end
    end

    assign kg_start      = r_pending && !kg_busy && !ci_busy;
    assign s_axis_tready = !r_pending && !kg_busy && !ci_busy;
    assign accept        = s_axis_tvalid && s_axis_tready;

    aesb_keygen u_keygen (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (kg_start),
        .i_key   ({r_key_high, r_key_low}),
        .o_busy  (kg_busy),
        .o_wr    (kg_wr)
    );

    aesb_rkmem u_rkmem (
        .i_clk   (i_clk),
        .i_wr    (kg_wr),
        .i_raddr (raddr),
        .o_rdata (rk)
    );

    aesb_cipher u_cipher (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (accept),
        .i_plain     ({s_axis_tdata[63:0], s_axis_tdata[127:64]}),
        .i_rk        (rk),
        .o_raddr     (raddr),
        .o_busy      (ci_busy),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_cipher    (cipher)
    );

    assign m_axis_tdata = {cipher[63:0], cipher[127:64]};

    `AESB_ASSERT_SAME(a_no_accept_stale_key, i_clk, i_rst_n, accept, !r_pending && !kg_busy, "block accepted while key memory stale")
    `AESB_ASSERT_SAME(a_no_write_in_round, i_clk, i_rst_n, kg_wr.we, !ci_busy, "key memory written during encryption")
    `AESB_ASSERT_NEXT(a_accept_starts, i_clk, i_rst_n, accept, ci_busy && !s_axis_tready, "accepted block did not start rounds")

endmodule

@@ verif/aes128_block_encrypt_core_test.sv @@
module aes128_block_encrypt_core_test
    import aesb_pkg::*;
();

    localparam int HALF_PERIOD    = 6;
    localparam int RESET_CYCLES   = 10;
    localparam int HOLDOFF_CYCLES = 300;
    localparam int TAIL_CYCLES    = 24;
    localparam int CYCLE_LIMIT    = 200000;
    localparam int SCHED_WORDS    = 44;

    typedef struct packed {
        logic [63:0] high;
        logic [63:0] low;
    } t_cipher;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [127:0] s_axis_tdata = '0;   // plain_high [63:0], plain_low [127:64]
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [127:0] m_axis_tdata;        // cipher_high [63:0], cipher_low [127:64]
    logic         i_cfg_we = 1'b0;
    logic         i_cfg_addr = CFG_KEY_HIGH;
    logic [63:0]  i_cfg_wdata = '0;

    // Predictor state: key registers, expanded schedule, S-box table
    logic [63:0] key_high_q = '0;
    logic [63:0] key_low_q = '0;
    logic [31:0] key_schedule [SCHED_WORDS];
    logic [7:0]  sub_table [256];

    t_cipher expected_ciphers [$];
    int      mismatch_count = 0;
    int      cycle_count = 0;
    logic    no_idle = 1'b0;
    int      holdoff_reqs = 0;
    int      holdoff_seen = 0;
    int      holdoff_left = 0;

    aes128_block_encrypt_core DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_addr   (i_cfg_addr),
        .i_cfg_wdata  (i_cfg_wdata)
    );

    always #HALF_PERIOD i_clk = ~i_clk;

    // Multiply by x modulo the field polynomial
    function automatic logic [7:0] gf_double(input logic [7:0] x);
        return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] p;
        p = '0;
        for (int i = 0; i < 8; i++) begin
            if (b[0]) p ^= a;
            a = gf_double(a);
            b = b >> 1;
        end
        return p;
    endfunction

    // Field inverse as x^254, then the affine map
    function automatic logic [7:0] sbox_of(input logic [7:0] x);
        logic [7:0] inv;
        logic [7:0] base;
        int         e;
        inv  = 8'h01;
        base = x;
        e    = 254;
        while (e != 0) begin
            if (e & 1) inv = gf_mul(inv, base);
            base = gf_mul(base, base);
            e = e >> 1;
        end
        return inv ^ {inv[6:0], inv[7]} ^ {inv[5:0], inv[7:6]} ^
               {inv[4:0], inv[7:5]} ^ {inv[3:0], inv[7:4]} ^ 8'h63;
    endfunction

    // Full AES-128 encryption of one block under the current schedule
    function automatic t_cipher aes_encrypt_block(input logic [63:0] hi, input logic [63:0] lo);
        logic [7:0]  st [16];
        logic [7:0]  shifted [16];
        logic [7:0]  a0, a1, a2, a3, all;
        logic [31:0] w;
        t_cipher     res;
        for (int i = 0; i < 8; i++) begin
            st[i]     = hi[63 - 8 * i -: 8];
            st[8 + i] = lo[63 - 8 * i -: 8];
        end
        for (int rnd = 0; rnd <= ROUNDS; rnd++) begin
            if (rnd > 0) begin
                // substitute and shift rows
                for (int c = 0; c < 4; c++)
                    for (int r = 0; r < 4; r++)
                        shifted[4 * c + r] = sub_table[st[4 * ((c + r) % 4) + r]];
                st = shifted;
                // mix columns on all but the last round
                if (rnd < ROUNDS) begin
                    for (int c = 0; c < 4; c++) begin
                        a0  = st[4 * c];
                        a1  = st[4 * c + 1];
                        a2  = st[4 * c + 2];
                        a3  = st[4 * c + 3];
                        all = a0 ^ a1 ^ a2 ^ a3;
                        st[4 * c]     = a0 ^ all ^ gf_double(a0 ^ a1);
                        st[4 * c + 1] = a1 ^ all ^ gf_double(a1 ^ a2);
                        st[4 * c + 2] = a2 ^ all ^ gf_double(a2 ^ a3);
                        st[4 * c + 3] = a3 ^ all ^ gf_double(a3 ^ a0);
                    end
                end
            end
            // add the round key
            for (int c = 0; c < 4; c++) begin
                w = key_schedule[rnd * 4 + c];
                for (int r = 0; r < 4; r++)
                    st[4 * c + r] ^= w[31 - 8 * r -: 8];
            end
        end
        for (int i = 0; i < 8; i++) begin
            res.high[63 - 8 * i -: 8] = st[i];
            res.low[63 - 8 * i -: 8]  = st[8 + i];
        end
        return res;
    endfunction

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    // Mostly random halves, with the occasional all-zero or all-one half
    function automatic logic [63:0] random_half();
        case ($urandom_range(0, 15))
            0:       return '0;
            1:       return '1;
            default: return rand64();
        endcase
    endfunction

    // Offer one plaintext block and hold it until the transaction completes
    task automatic send_block(input logic [63:0] hi, input logic [63:0] lo);
        if (!no_idle && $urandom_range(0, 99) < 16) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {lo, hi};
        do @(posedge i_clk); while (!s_axis_tready);
        expected_ciphers.push_back(aes_encrypt_block(hi, lo));
    endtask

    // Drop valid and wait until every ciphertext has come back
    task automatic wait_for_ciphers();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (expected_ciphers.size() != 0);
    endtask

    task automatic cfg_write(input logic addr, input logic [63:0] value);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= addr;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        if (addr == CFG_KEY_HIGH) key_high_q = value;
        else key_low_q = value;
    endtask

    // Write one or both key registers while idle, then rebuild the schedule
    task automatic load_key(input bit write_high, input bit write_low,
                            input logic [63:0] high_val, input logic [63:0] low_val);
        logic [31:0] t;
        logic [7:0]  rcon;
        wait_for_ciphers();
        if (write_high) cfg_write(CFG_KEY_HIGH, high_val);
        if (write_low) cfg_write(CFG_KEY_LOW, low_val);
        i_cfg_we <= 1'b0;
        key_schedule[0] = key_high_q[63:32];
        key_schedule[1] = key_high_q[31:0];
        key_schedule[2] = key_low_q[63:32];
        key_schedule[3] = key_low_q[31:0];
        rcon = 8'h01;
        for (int w = 4; w < SCHED_WORDS; w++) begin
            t = key_schedule[w - 1];
            if (w % 4 == 0) begin
                t = {t[23:0], t[31:24]};
                t = {sub_table[t[31:24]], sub_table[t[23:16]],
                     sub_table[t[15:8]], sub_table[t[7:0]]} ^ {rcon, 24'h0};
                rcon = gf_double(rcon);
            end
            key_schedule[w] = key_schedule[w - 4] ^ t;
        end
    endtask

    task automatic test_known_vectors();
        load_key(1, 1, 64'h0001020304050607, 64'h08090a0b0c0d0e0f);
        send_block(64'h0011223344556677, 64'h8899aabbccddeeff);
        send_block(64'h0000000000000000, 64'h0000000000000000);
        send_block(64'hffffffffffffffff, 64'hffffffffffffffff);
    endtask

    task automatic test_key_extremes();
        load_key(1, 1, '0, '0);
        send_block('0, '0);
        send_block('1, '1);
        send_block(64'h0011223344556677, 64'h8899aabbccddeeff);
        load_key(1, 1, '1, '1);
        send_block('0, '0);
        send_block('1, '1);
        send_block(64'h0011223344556677, 64'h8899aabbccddeeff);
    endtask

    // Only one key register changes; the other must still take part
    task automatic test_partial_key_update();
        load_key(1, 0, 64'h2b7e151628aed2a6, '0);
        send_block(64'h3243f6a8885a308d, 64'h313198a2e0370734);
        send_block(64'h6bc1bee22e409f96, 64'he93d7e117393172a);
        load_key(0, 1, '0, 64'habf7158809cf4f3c);
        send_block(64'h3243f6a8885a308d, 64'h313198a2e0370734);
        send_block(64'h6bc1bee22e409f96, 64'he93d7e117393172a);
    endtask

    // Long stretch with no idling on either side
    task automatic test_back_to_back();
        no_idle <= 1'b1;
        for (int n = 0; n < 20; n++) send_block(random_half(), random_half());
        wait_for_ciphers();
        no_idle <= 1'b0;
    endtask

    // Receiver holds off while the sender keeps offering blocks
    task automatic test_output_holdoff();
        @(posedge i_clk);
        no_idle      <= 1'b1;
        holdoff_reqs <= holdoff_reqs + 1;
        for (int n = 0; n < 24; n++) send_block(random_half(), random_half());
        wait_for_ciphers();
        no_idle <= 1'b0;
    endtask

    // Sender pauses until every ciphertext has drained, then resumes
    task automatic test_drain_pause();
        for (int n = 0; n < 10; n++) send_block(random_half(), random_half());
        wait_for_ciphers();
        for (int n = 0; n < 10; n++) send_block(random_half(), random_half());
    endtask

    // Random blocks over several keys, with full and partial key updates
    task automatic test_random_traffic();
        for (int phase = 0; phase < 6; phase++) begin
            case (phase % 3)
                0:       load_key(1, 1, rand64(), rand64());
                1:       load_key(0, 1, '0, rand64());
                default: load_key(1, 0, rand64(), '0);
            endcase
            for (int n = 0; n < 90; n++) send_block(random_half(), random_half());
        end
    endtask

    // Receiver side: random stalls, steady stretches and a counted hold-off
    always @(posedge i_clk) begin
        if (holdoff_seen != holdoff_reqs) begin
            holdoff_seen  <= holdoff_reqs;
            holdoff_left  <= HOLDOFF_CYCLES;
            m_axis_tready <= 1'b0;
        end else if (holdoff_left != 0) begin
            holdoff_left  <= holdoff_left - 1;
            m_axis_tready <= 1'b0;
        end else if (no_idle) begin
            m_axis_tready <= 1'b1;
        end else begin
            m_axis_tready <= ($urandom_range(0, 99) >= 16);
        end
    end

    // Compare each ciphertext transaction with the oldest prediction
    always @(posedge i_clk) begin
        t_cipher want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (expected_ciphers.size() == 0) begin
                $error("unexpected ciphertext block %032h", m_axis_tdata);
                mismatch_count++;
            end else begin
                want = expected_ciphers.pop_front();
                if (m_axis_tdata[63:0] !== want.high) begin
                    $error("cipher_high mismatch: expected %016h, actual %016h",
                           want.high, m_axis_tdata[63:0]);
                    mismatch_count++;
                end
                if (m_axis_tdata[127:64] !== want.low) begin
                    $error("cipher_low mismatch: expected %016h, actual %016h",
                           want.low, m_axis_tdata[127:64]);
                    mismatch_count++;
                end
            end
        end
    end

    // Bound the run
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("FAIL aes128_block_encrypt_core");
            $finish;
        end
    end

    initial begin
        for (int v = 0; v < 256; v++) sub_table[v] = sbox_of(8'(v));
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_known_vectors();
        test_key_extremes();
        test_partial_key_update();
        test_back_to_back();
        test_output_holdoff();
        test_drain_pause();
        test_random_traffic();

        wait_for_ciphers();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0 && expected_ciphers.size() == 0) begin
            $display("PASS aes128_block_encrypt_core");
        end else begin
            $display("FAIL aes128_block_encrypt_core");
        end
        $finish;
    end

endmodule
